// ===== hw/rtl/pts_pkg.sv =====
// Shared types, constants and helper functions of the priority task scheduler.
`default_nettype none
package pts_pkg;

  localparam int TASK_SLOTS  = 16;
  localparam int PRIO_LEVELS = 8;
  localparam int SLOT_W      = $clog2(TASK_SLOTS);
  localparam int PRIO_W      = $clog2(PRIO_LEVELS);
  localparam int RANK_W      = SLOT_W;
  localparam int CNT_W       = SLOT_W + 1;
  localparam int SLICE_W     = 5;
  localparam int WAIT_W      = 17;
  localparam int TMO_W       = 16;
  localparam int ACT_W       = 3;
  localparam int TST_W       = 3;
  localparam int TPRIO_W     = 4;
  localparam int STATUS_W    = 2;
  localparam int WOKEN_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int SLICE_MAX   = (1 << SLICE_W) - 1;

  // Slot state codes
  localparam logic [TST_W-1:0] SS_UNKNOWN = 3'd0;
  localparam logic [TST_W-1:0] SS_READY   = 3'd1;
  localparam logic [TST_W-1:0] SS_RUNNING = 3'd2;
  localparam logic [TST_W-1:0] SS_SLEEP   = 3'd3;
  localparam logic [TST_W-1:0] SS_IDLE    = 3'd4;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_SET_STATE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SET_PRIO  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TICK      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_YIELD     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SLEEP     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_WAKE      = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXEMPT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE  = 2'd2;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SET_STATE,
    OP_SET_PRIO,
    OP_WAIT_DEC,
    OP_WALK,
    OP_SLICE_DEC,
    OP_SLEEP,
    OP_WAKE,
    OP_BAD,
    OP_PICK,
    OP_SELF,
    OP_DEMOTE,
    OP_REQUEUE,
    OP_RUN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             sched_en;
    logic             sleep_ok;
    logic             walk_done;
    logic             slice_zero;
    logic             pick_self;
  } dp_stat_t;

  // Legal slot state transitions
  function automatic logic legal_change(input logic [TST_W-1:0] old_st,
                                        input logic [TST_W-1:0] new_st);
    logic ok;
    case (old_st)
      SS_UNKNOWN: ok = new_st inside {SS_READY, SS_SLEEP};
      SS_READY:   ok = new_st inside {SS_RUNNING, SS_SLEEP, SS_IDLE, SS_UNKNOWN};
      SS_RUNNING: ok = new_st inside {SS_SLEEP, SS_READY, SS_IDLE};
      SS_SLEEP:   ok = new_st inside {SS_READY, SS_IDLE, SS_RUNNING};
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Time slice: base plus distance from the level count, saturated
  function automatic logic [SLICE_W-1:0] slice_for(input logic [PRIO_W-1:0] prio,
                                                   input logic [SLICE_W-1:0] base);
    logic [SLICE_W:0] v;
    v = (SLICE_W+1)'(base) + (SLICE_W+1)'(PRIO_LEVELS) - (SLICE_W+1)'(prio);
    return (v > (SLICE_W+1)'(SLICE_MAX)) ? SLICE_W'(SLICE_MAX) : v[SLICE_W-1:0];
  endfunction

  // Drop one level; a non-exempt slot landing on the lowest level wraps to the top
  function automatic logic [PRIO_W-1:0] demote(input logic [PRIO_W-1:0] prio,
                                               input logic exempt);
    logic [PRIO_W-1:0] p;
    p = prio;
    if (p < PRIO_W'(PRIO_LEVELS - 1)) p = p + 1'b1;
    if (!exempt && p == PRIO_W'(PRIO_LEVELS - 1)) p = '0;
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pts_dp.sv =====
// Scheduler datapath: slot tables, queue ranks, configuration and result registers.
`default_nettype none
module pts_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire pts_pkg::dp_cmd_t                cmd,
  output pts_pkg::dp_stat_t                    stat,
  input  wire logic [pts_pkg::ACT_W-1:0]       in_action,
  input  wire logic [pts_pkg::SLOT_W-1:0]      in_task_slot,
  input  wire logic [pts_pkg::TST_W-1:0]       in_target_state,
  input  wire logic [pts_pkg::TPRIO_W-1:0]     in_target_priority,
  input  wire logic [pts_pkg::TMO_W-1:0]       in_timeout_ticks,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [pts_pkg::STATUS_W-1:0]         out_status,
  output logic [pts_pkg::SLOT_W-1:0]           out_running_task,
  output logic                                 out_switched,
  output logic [pts_pkg::WOKEN_W-1:0]          out_woken_count
);
  import pts_pkg::*;

  // Per-slot tables
  logic [TST_W-1:0]   st_r     [TASK_SLOTS];
  logic [TST_W-1:0]   st_nxt   [TASK_SLOTS];
  logic [PRIO_W-1:0]  prio_r   [TASK_SLOTS];
  logic [PRIO_W-1:0]  prio_nxt [TASK_SLOTS];
  logic [SLICE_W-1:0] slice_r  [TASK_SLOTS];
  logic [SLICE_W-1:0] slice_nxt[TASK_SLOTS];
  logic [WAIT_W-1:0]  wait_r   [TASK_SLOTS];
  logic [WAIT_W-1:0]  wait_nxt [TASK_SLOTS];
  logic [RANK_W-1:0]  rrank_r  [TASK_SLOTS];
  logic [RANK_W-1:0]  rrank_nxt[TASK_SLOTS];
  logic [RANK_W-1:0]  srank_r  [TASK_SLOTS];
  logic [RANK_W-1:0]  srank_nxt[TASK_SLOTS];

  // Queue fill counts
  logic [CNT_W-1:0]   rcnt_r   [PRIO_LEVELS];
  logic [CNT_W-1:0]   rcnt_nxt [PRIO_LEVELS];
  logic [CNT_W-1:0]   scnt_r, scnt_nxt;

  logic [SLOT_W-1:0]  cur_r, cur_nxt;
  logic [SLOT_W-1:0]  next_r, next_nxt;
  logic [CNT_W-1:0]   walk_r, walk_nxt;

  // Latched command
  logic [ACT_W-1:0]   act_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [TST_W-1:0]   tstate_r;
  logic [TPRIO_W-1:0] tprio_r;
  logic [TMO_W-1:0]   tmo_r;

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                switched_r, switched_nxt;
  logic [WOKEN_W-1:0]  woken_r, woken_nxt;

  // Configuration
  logic               en_r;
  logic [SLOT_W-1:0]  exempt_r;
  logic [SLICE_W-1:0] base_r;

  logic [SLOT_W-1:0]  tgt;
  logic               found;
  logic [SLOT_W-1:0]  found_slot;
  logic               lvl_hit;
  logic [PRIO_W-1:0]  lvl;
  logic               pick_hit;
  logic [SLOT_W-1:0]  pick_slot;

  assign cfg_ready = 1'b1;

  // Select the one slot this micro-operation addresses
  always_comb begin
    case (cmd.op)
      OP_SET_STATE, OP_SET_PRIO, OP_SLEEP, OP_WAKE: tgt = slot_r;
      OP_WALK:                                      tgt = found_slot;
      OP_RUN:                                       tgt = next_r;
      default:                                      tgt = cur_r;
    endcase
  end

  // Find the sleeper at the current walk position
  always_comb begin
    found      = 1'b0;
    found_slot = '0;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (st_r[j] == SS_SLEEP && {1'b0, srank_r[j]} == walk_r) begin
        found      = 1'b1;
        found_slot = SLOT_W'(j);
      end
    end
  end

  // Find the head of the most urgent non-empty level above the lowest
  always_comb begin
    lvl_hit   = 1'b0;
    lvl       = '0;
    pick_hit  = 1'b0;
    pick_slot = '0;
    for (int i = PRIO_LEVELS - 2; i >= 0; i--) begin
      if (rcnt_r[i] != '0) begin
        lvl_hit = 1'b1;
        lvl     = PRIO_W'(i);
      end
    end
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (lvl_hit && st_r[j] == SS_READY && prio_r[j] == lvl && rrank_r[j] == '0) begin
        pick_hit  = 1'b1;
        pick_slot = SLOT_W'(j);
      end
    end
  end

  // Status towards the controller
  always_comb begin
    stat.action     = act_r;
    stat.sched_en   = en_r;
    stat.sleep_ok   = (tmo_r != '0) && (st_r[tgt] != SS_IDLE);
    stat.walk_done  = (walk_r == scnt_r);
    stat.slice_zero = (slice_r[tgt] == '0);
    stat.pick_self  = (next_r == cur_r);
  end

  // Next-state logic of the tables
  always_comb begin
    logic              chg_en;
    logic              chg_ok;
    logic [TST_W-1:0]  chg_new;
    logic [TST_W-1:0]  old_st;
    logic [PRIO_W-1:0] lo;
    logic [PRIO_W-1:0] ln;
    logic [PRIO_W-1:0] dp;

    st_nxt       = st_r;
    prio_nxt     = prio_r;
    slice_nxt    = slice_r;
    wait_nxt     = wait_r;
    rrank_nxt    = rrank_r;
    srank_nxt    = srank_r;
    rcnt_nxt     = rcnt_r;
    scnt_nxt     = scnt_r;
    cur_nxt      = cur_r;
    next_nxt     = next_r;
    walk_nxt     = walk_r;
    status_nxt   = status_r;
    switched_nxt = switched_r;
    woken_nxt    = woken_r;
    chg_en       = 1'b0;
    chg_ok       = 1'b0;
    chg_new      = SS_READY;
    old_st       = st_r[tgt];
    lo           = prio_r[tgt];
    ln           = tprio_r[PRIO_W-1:0];
    dp           = demote(prio_r[tgt], tgt == exempt_r);

    case (cmd.op)
      OP_LATCH: begin
        status_nxt   = STAT_DONE;
        switched_nxt = 1'b0;
        woken_nxt    = '0;
        walk_nxt     = '0;
      end
      OP_SET_STATE: begin
        chg_en  = 1'b1;
        chg_new = tstate_r;
      end
      OP_SET_PRIO: begin
        if ({1'b0, tprio_r} >= (TPRIO_W+1)'(PRIO_LEVELS)) begin
          status_nxt = STAT_INVALID;
        end else begin
          case (old_st)
            SS_RUNNING, SS_SLEEP: begin
              prio_nxt[tgt] = ln;
            end
            SS_READY: begin
              // pull out of the old level, append to the new one
              for (int j = 0; j < TASK_SLOTS; j++) begin
                if (st_r[j] == SS_READY && prio_r[j] == lo && rrank_r[j] > rrank_r[tgt])
                  rrank_nxt[j] = rrank_r[j] - 1'b1;
              end
              rcnt_nxt[lo]   = rcnt_r[lo] - 1'b1;
              rrank_nxt[tgt] = rcnt_nxt[ln][RANK_W-1:0];
              rcnt_nxt[ln]   = rcnt_nxt[ln] + 1'b1;
              prio_nxt[tgt]  = ln;
            end
            default: status_nxt = STAT_INVALID;
          endcase
        end
      end
      OP_WAIT_DEC: begin
        for (int j = 0; j < TASK_SLOTS; j++) begin
          if (st_r[j] == SS_SLEEP && !wait_r[j][WAIT_W-1] && wait_r[j] != '0)
            wait_nxt[j] = wait_r[j] - 1'b1;
        end
      end
      OP_WALK: begin
        if (found && wait_r[tgt] == '0) begin
          chg_en    = 1'b1;
          chg_new   = SS_READY;
          woken_nxt = woken_r + 1'b1;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end
      OP_SLICE_DEC: begin
        slice_nxt[tgt] = slice_r[tgt] - 1'b1;
      end
      OP_SLEEP: begin
        if (!stat.sleep_ok) begin
          status_nxt = STAT_INVALID;
        end else begin
          wait_nxt[tgt] = {1'b0, tmo_r};
          chg_en        = 1'b1;
          chg_new       = SS_SLEEP;
        end
      end
      OP_WAKE: begin
        if (old_st != SS_SLEEP) begin
          status_nxt = STAT_INVALID;
        end else begin
          slice_nxt[tgt] = slice_for(prio_r[tgt], base_r);
          chg_en         = 1'b1;
          chg_new        = SS_READY;
        end
      end
      OP_BAD: begin
        status_nxt = STAT_INVALID;
      end
      OP_PICK: begin
        next_nxt     = pick_hit ? pick_slot : cur_r;
        switched_nxt = 1'b1;
      end
      OP_SELF: begin
        slice_nxt[tgt] = slice_for(prio_r[tgt], base_r);
      end
      OP_DEMOTE: begin
        if (old_st == SS_RUNNING && (slice_r[tgt] == '0 || act_r != ACT_TICK)) begin
          prio_nxt[tgt]  = dp;
          slice_nxt[tgt] = slice_for(dp, base_r);
        end
      end
      OP_REQUEUE: begin
        if (old_st == SS_RUNNING) begin
          chg_en  = 1'b1;
          chg_new = SS_READY;
        end
      end
      OP_RUN: begin
        wait_nxt[tgt] = '1;
        chg_en        = 1'b1;
        chg_new       = SS_RUNNING;
        cur_nxt       = next_r;
      end
      default: ;
    endcase

    // Apply a state change of the addressed slot and keep queue ranks in order
    if (chg_en && legal_change(old_st, chg_new)) begin
      chg_ok       = 1'b1;
      st_nxt[tgt]  = chg_new;
      if (old_st == SS_READY) begin
        for (int j = 0; j < TASK_SLOTS; j++) begin
          if (st_r[j] == SS_READY && prio_r[j] == lo && rrank_r[j] > rrank_r[tgt])
            rrank_nxt[j] = rrank_r[j] - 1'b1;
        end
        rcnt_nxt[lo] = rcnt_r[lo] - 1'b1;
      end
      if (old_st == SS_SLEEP) begin
        for (int j = 0; j < TASK_SLOTS; j++) begin
          if (st_r[j] == SS_SLEEP && srank_r[j] > srank_r[tgt])
            srank_nxt[j] = srank_r[j] - 1'b1;
        end
        scnt_nxt = scnt_r - 1'b1;
      end
      if (chg_new == SS_READY) begin
        rrank_nxt[tgt] = rcnt_nxt[lo][RANK_W-1:0];
        rcnt_nxt[lo]   = rcnt_nxt[lo] + 1'b1;
      end
      if (chg_new == SS_SLEEP) begin
        if (old_st == SS_UNKNOWN) begin
          for (int j = 0; j < TASK_SLOTS; j++) begin
            if (st_r[j] == SS_SLEEP) srank_nxt[j] = srank_r[j] + 1'b1;
          end
          srank_nxt[tgt] = '0;
        end else begin
          srank_nxt[tgt] = scnt_r[RANK_W-1:0];
        end
        scnt_nxt = scnt_nxt + 1'b1;
      end
    end
    if (cmd.op == OP_SET_STATE && !chg_ok) status_nxt = STAT_IGNORED;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TASK_SLOTS; j++) begin
        st_r[j]    <= SS_UNKNOWN;
        prio_r[j]  <= '0;
        slice_r[j] <= '0;
        wait_r[j]  <= '1;
      end
      for (int i = 0; i < PRIO_LEVELS; i++) rcnt_r[i] <= '0;
      scnt_r   <= '0;
      cur_r    <= '0;
      en_r     <= 1'b0;
      exempt_r <= '0;
      base_r   <= SLICE_W'(5);
    end else begin
      st_r    <= st_nxt;
      prio_r  <= prio_nxt;
      slice_r <= slice_nxt;
      wait_r  <= wait_nxt;
      rcnt_r  <= rcnt_nxt;
      scnt_r  <= scnt_nxt;
      cur_r   <= cur_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ENABLE: en_r     <= cfg_data[0];
          CFG_EXEMPT: exempt_r <= cfg_data[SLOT_W-1:0];
          CFG_SLICE:  base_r   <= cfg_data[SLICE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload: ranks, latched command, result
  always_ff @(posedge clk) begin
    rrank_r    <= rrank_nxt;
    srank_r    <= srank_nxt;
    next_r     <= next_nxt;
    walk_r     <= walk_nxt;
    status_r   <= status_nxt;
    switched_r <= switched_nxt;
    woken_r    <= woken_nxt;
    if (cmd.op == OP_LATCH) begin
      act_r    <= in_action;
      slot_r   <= in_task_slot;
      tstate_r <= in_target_state;
      tprio_r  <= in_target_priority;
      tmo_r    <= in_timeout_ticks;
    end
    if (cmd.out_load) begin
      out_status       <= status_r;
      out_running_task <= cur_r;
      out_switched     <= switched_r;
      out_woken_count  <= woken_r;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pts_ctrl.sv =====
// Scheduler controller: sequences the micro-operations of each command.
`default_nettype none
module pts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pts_pkg::dp_cmd_t       cmd,
  input  wire pts_pkg::dp_stat_t stat
);
  import pts_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EXEC   = 9'b000000010,
    S_WALK   = 9'b000000100,
    S_TESTSL = 9'b000001000,
    S_PICK   = 9'b000010000,
    S_CHOOSE = 9'b000100000,
    S_REQ    = 9'b001000000,
    S_RUN    = 9'b010000000,
    S_OUT    = 9'b100000000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequence the command
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.action)
          ACT_SET_STATE: begin
            cmd.op    = OP_SET_STATE;
            state_nxt = S_OUT;
          end
          ACT_SET_PRIO: begin
            cmd.op    = OP_SET_PRIO;
            state_nxt = S_OUT;
          end
          ACT_TICK: begin
            cmd.op    = OP_WAIT_DEC;
            state_nxt = S_WALK;
          end
          ACT_YIELD: begin
            state_nxt = stat.sched_en ? S_PICK : S_OUT;
          end
          ACT_SLEEP: begin
            cmd.op    = OP_SLEEP;
            state_nxt = (stat.sleep_ok && stat.sched_en) ? S_PICK : S_OUT;
          end
          ACT_WAKE: begin
            cmd.op    = OP_WAKE;
            state_nxt = S_OUT;
          end
          default: begin
            cmd.op    = OP_BAD;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_WALK: begin
        if (stat.walk_done) begin
          cmd.op    = OP_SLICE_DEC;
          state_nxt = S_TESTSL;
        end else begin
          cmd.op = OP_WALK;
        end
      end
      S_TESTSL: begin
        state_nxt = stat.slice_zero ? S_PICK : S_OUT;
      end
      S_PICK: begin
        cmd.op    = OP_PICK;
        state_nxt = S_CHOOSE;
      end
      S_CHOOSE: begin
        if (stat.pick_self) begin
          cmd.op    = OP_SELF;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_DEMOTE;
          state_nxt = S_REQ;
        end
      end
      S_REQ: begin
        cmd.op    = OP_REQUEUE;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.op    = OP_RUN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Track the result beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/priority_task_scheduler.sv =====
// Top level of the priority task scheduler: controller, datapath and checks.
`default_nettype none
// One command beat in, one result beat out. Sixteen task slots, eight priority
// levels with FIFO ready queues and one ordered sleep list; all tables sit in
// flip-flops so that queue inserts and removals update every slot at once.
// A command passes through the accept, execute and result states (set state,
// set priority, wakeup, yield or sleep without rescheduling). A scheduling
// decision adds the pick, choose, requeue and run states, or only pick and
// choose when the current task is chosen again. A tick decrements the waits,
// then walks the sleepers on the list one per cycle in list order and counts
// down the slice, plus the decision when the slice runs out. A new command is
// taken while the previous result still waits in the output register.
// Configuration writes are taken in any cycle and should be made while idle.
module priority_task_scheduler (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [pts_pkg::ACT_W-1:0]       in_action,
  input  wire logic [pts_pkg::SLOT_W-1:0]      in_task_slot,
  input  wire logic [pts_pkg::TST_W-1:0]       in_target_state,
  input  wire logic [pts_pkg::TPRIO_W-1:0]     in_target_priority,
  input  wire logic [pts_pkg::TMO_W-1:0]       in_timeout_ticks,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [pts_pkg::STATUS_W-1:0]         out_status,
  output logic [pts_pkg::SLOT_W-1:0]           out_running_task,
  output logic                                 out_switched,
  output logic [pts_pkg::WOKEN_W-1:0]          out_woken_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pts_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_action),
    .in_task_slot       (in_task_slot),
    .in_target_state    (in_target_state),
    .in_target_priority (in_target_priority),
    .in_timeout_ticks   (in_timeout_ticks),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_status         (out_status),
    .out_running_task   (out_running_task),
    .out_switched       (out_switched),
    .out_woken_count    (out_woken_count)
  );

  // One command at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while previous one in flight");

  // Only a tick wakes sleepers, and a tick always completes
  a_woken_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_woken_count != '0 |-> out_status == STAT_DONE)
    else $error("sleepers woken by a failed command");

  // An ignored state change neither reschedules nor wakes
  a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_IGNORED |-> !out_switched && out_woken_count == '0)
    else $error("ignored command reported side effects");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the priority task scheduler, with a scoreboard and a behavioural model.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  typedef struct {
    int act;
    int slot;
    int tstate;
    int tprio;
    int tmo;
  } sched_cmd_t;

  typedef struct {
    int status;
    int running;
    int switched;
    int woken;
  } sched_result_t;

  typedef struct {
    sched_cmd_t    cmd;
    bit            fixed;
    sched_result_t want;
  } directed_row_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SLEEP_CHAIN = PRIO_LEVELS;   // chain index of the sleep list
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 260;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACT_W-1:0] in_action = '0;
  logic [SLOT_W-1:0] in_task_slot = '0;
  logic [TST_W-1:0] in_target_state = '0;
  logic [TPRIO_W-1:0] in_target_priority = '0;
  logic [TMO_W-1:0] in_timeout_ticks = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0] out_running_task;
  logic out_switched;
  logic [WOKEN_W-1:0] out_woken_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  priority_task_scheduler dut (.*);

  always #1 clk = ~clk;

  // Scheduler model state
  int slot_st[TASK_SLOTS];
  int slot_pri[TASK_SLOTS];
  int slot_prev_pri[TASK_SLOTS];
  int slot_slice[TASK_SLOTS];
  int slot_wait[TASK_SLOTS];
  int slot_tmo_flag[TASK_SLOTS];
  int unsigned slot_runs[TASK_SLOTS];
  int chain_link[2][TASK_SLOTS];
  int chain_head[PRIO_LEVELS+1];
  int chain_tail[PRIO_LEVELS+1];
  int chain_cnt[PRIO_LEVELS+1];
  int cur_task;
  int en_reg;
  int exempt_reg;
  int base_reg;

  sched_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int woke_total = 0;
  int switch_total = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  function automatic int link_set(int c);
    return (c == SLEEP_CHAIN) ? 1 : 0;
  endfunction

  function automatic void chain_push_back(int c, int s);
    if (chain_cnt[c] == 0) chain_head[c] = s;
    else chain_link[link_set(c)][chain_tail[c]] = s;
    chain_tail[c] = s;
    chain_cnt[c]++;
  endfunction

  function automatic void chain_push_front(int c, int s);
    chain_link[link_set(c)][s] = chain_head[c];
    if (chain_cnt[c] == 0) chain_tail[c] = s;
    chain_head[c] = s;
    chain_cnt[c]++;
  endfunction

  function automatic void chain_unlink(int c, int s);
    int prev;
    int p;
    int ls;
    prev = -1;
    p = chain_head[c];
    ls = link_set(c);
    for (int k = 0; k < chain_cnt[c]; k++) begin
      if (p == s) begin
        if (prev < 0) chain_head[c] = chain_link[ls][p];
        else chain_link[ls][prev] = chain_link[ls][p];
        if (chain_tail[c] == s) chain_tail[c] = (prev < 0) ? 0 : prev;
        chain_cnt[c]--;
        return;
      end
      prev = p;
      p = chain_link[ls][p];
    end
  endfunction

  function automatic int slice_len(int s);
    int v;
    v = base_reg + PRIO_LEVELS - slot_pri[s];
    return (v > SLICE_MAX) ? SLICE_MAX : v;
  endfunction

  function automatic bit move_slot(int s, int nw);
    int old;
    bit ok;
    old = slot_st[s];
    case (old)
      SS_UNKNOWN: ok = (nw == SS_READY || nw == SS_SLEEP);
      SS_READY:   ok = (nw == SS_RUNNING || nw == SS_SLEEP || nw == SS_IDLE ||
                        nw == SS_UNKNOWN);
      SS_RUNNING: ok = (nw == SS_SLEEP || nw == SS_READY || nw == SS_IDLE);
      SS_SLEEP:   ok = (nw == SS_READY || nw == SS_IDLE || nw == SS_RUNNING);
      default:    ok = 1'b0;
    endcase
    if (!ok) return 1'b0;
    slot_st[s] = nw;
    if (old == SS_READY) chain_unlink(slot_pri[s] % PRIO_LEVELS, s);
    if (old == SS_SLEEP) chain_unlink(SLEEP_CHAIN, s);
    if (nw == SS_READY) chain_push_back(slot_pri[s] % PRIO_LEVELS, s);
    if (nw == SS_SLEEP) begin
      if (old == SS_UNKNOWN) chain_push_front(SLEEP_CHAIN, s);
      else chain_push_back(SLEEP_CHAIN, s);
    end
    return 1'b1;
  endfunction

  function automatic void pick_next(bit from_tick);
    int nxt;
    bit dummy;
    nxt = cur_task;
    for (int i = 0; i < PRIO_LEVELS - 1; i++) begin
      if (chain_cnt[i] != 0) begin
        nxt = chain_head[i];
        break;
      end
    end
    if (nxt == cur_task) begin
      slot_slice[nxt] = slice_len(nxt);
      slot_runs[nxt]++;
      return;
    end
    if (slot_st[cur_task] == SS_RUNNING) begin
      if (slot_slice[cur_task] == 0 || !from_tick) begin
        // demote one level, wrapping non-exempt slots off the lowest level
        if (slot_pri[cur_task] < PRIO_LEVELS - 1) slot_pri[cur_task]++;
        if (cur_task != exempt_reg && slot_pri[cur_task] == PRIO_LEVELS - 1)
          slot_pri[cur_task] = 0;
        slot_slice[cur_task] = slice_len(cur_task);
      end
      dummy = move_slot(cur_task, SS_READY);
    end
    if (slot_wait[nxt] == 0) slot_tmo_flag[nxt] = 1;
    slot_wait[nxt] = -1;
    dummy = move_slot(nxt, SS_RUNNING);
    cur_task = nxt;
    slot_runs[nxt]++;
  endfunction

  function automatic void sched_reset();
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slot_st[i] = SS_UNKNOWN;
      slot_pri[i] = 0;
      slot_prev_pri[i] = 0;
      slot_slice[i] = 0;
      slot_wait[i] = -1;
      slot_tmo_flag[i] = 0;
      slot_runs[i] = 0;
      chain_link[0][i] = 0;
      chain_link[1][i] = 0;
    end
    for (int c = 0; c <= PRIO_LEVELS; c++) begin
      chain_head[c] = 0;
      chain_tail[c] = 0;
      chain_cnt[c] = 0;
    end
    cur_task = 0;
    en_reg = 0;
    exempt_reg = 0;
    base_reg = 5;
  endfunction

  // Work out the result of one command and advance the model state
  function automatic sched_result_t schedule_cmd(sched_cmd_t c);
    sched_result_t r;
    int s;
    int p;
    int nx;
    int n;
    bit dummy;
    r = '{STAT_DONE, 0, 0, 0};
    s = c.slot;
    case (c.act)
      ACT_SET_STATE: if (!move_slot(s, c.tstate)) r.status = STAT_IGNORED;
      ACT_SET_PRIO: begin
        if (c.tprio >= PRIO_LEVELS) r.status = STAT_INVALID;
        else if (slot_st[s] == SS_RUNNING || slot_st[s] == SS_SLEEP) begin
          slot_prev_pri[s] = slot_pri[s];
          slot_pri[s] = c.tprio;
        end else if (slot_st[s] == SS_READY) begin
          chain_unlink(slot_pri[s] % PRIO_LEVELS, s);
          slot_prev_pri[s] = slot_pri[s];
          slot_pri[s] = c.tprio;
          chain_push_back(slot_pri[s] % PRIO_LEVELS, s);
        end else r.status = STAT_INVALID;
      end
      ACT_TICK: begin
        p = chain_head[SLEEP_CHAIN];
        n = chain_cnt[SLEEP_CHAIN];
        for (int k = 0; k < n; k++) begin
          nx = chain_link[1][p];
          if (slot_wait[p] > 0) slot_wait[p]--;
          if (slot_wait[p] == 0 && move_slot(p, SS_READY)) r.woken++;
          p = nx;
        end
        slot_slice[cur_task] = (slot_slice[cur_task] - 1) & SLICE_MAX;
        if (slot_slice[cur_task] == 0) begin
          pick_next(1'b1);
          r.switched = 1;
        end
      end
      ACT_YIELD: if (en_reg != 0) begin
        pick_next(1'b0);
        r.switched = 1;
      end
      ACT_SLEEP: begin
        if (c.tmo == 0 || slot_st[s] == SS_IDLE) r.status = STAT_INVALID;
        else begin
          slot_wait[s] = c.tmo;
          slot_tmo_flag[s] = 0;
          dummy = move_slot(s, SS_SLEEP);
          if (en_reg != 0) begin
            pick_next(1'b0);
            r.switched = 1;
          end
        end
      end
      ACT_WAKE: begin
        if (slot_st[s] != SS_SLEEP) r.status = STAT_INVALID;
        else begin
          slot_slice[s] = slice_len(s);
          dummy = move_slot(s, SS_READY);
        end
      end
      default: r.status = STAT_INVALID;
    endcase
    r.running = cur_task;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    sched_result_t w;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", 1, 0);
      end else begin
        w = pending_results.pop_front();
        if (int'(out_status) != w.status)
          report_mismatch("status", int'(out_status), w.status);
        if (int'(out_running_task) != w.running)
          report_mismatch("running_task", int'(out_running_task), w.running);
        if (int'(out_switched) != w.switched)
          report_mismatch("switched", int'(out_switched), w.switched);
        if (int'(out_woken_count) != w.woken)
          report_mismatch("woken_count", int'(out_woken_count), w.woken);
      end
    end
  end

  task automatic send_cmd(sched_cmd_t c, bit fixed, sched_result_t want);
    int gap;
    sched_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action <= ACT_W'(c.act);
    in_task_slot <= SLOT_W'(c.slot);
    in_target_state <= TST_W'(c.tstate);
    in_target_priority <= TPRIO_W'(c.tprio);
    in_timeout_ticks <= TMO_W'(c.tmo);
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = schedule_cmd(c);
    woke_total += r.woken;
    switch_total += r.switched;
    pending_results.push_back(fixed ? want : r);
  endtask

  task automatic cfg_write(int idx, int val);
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ENABLE) en_reg = val & 1;
    else if (idx == CFG_EXEMPT) exempt_reg = val & 15;
    else if (idx == CFG_SLICE) base_reg = val & 31;
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int r;
    c.act = $urandom_range(ACT_SET_STATE, ACT_WAKE);
    c.slot = $urandom_range(0, TASK_SLOTS - 1);
    c.tstate = $urandom_range(0, 7);
    c.tprio = $urandom_range(0, 15);
    c.tmo = $urandom_range(0, 65535);
    r = $urandom_range(0, 99);
    if (r < 30) c.act = ACT_TICK;
    else if (r < 45) begin
      c.act = ACT_SET_STATE;
      if ($urandom_range(0, 7) != 0) c.tstate = $urandom_range(SS_UNKNOWN, SS_IDLE);
    end else if (r < 54) begin
      c.act = ACT_SET_PRIO;
      if ($urandom_range(0, 5) != 0) c.tprio = $urandom_range(0, PRIO_LEVELS - 1);
    end else if (r < 66) c.act = ACT_YIELD;
    else if (r < 80) begin
      c.act = ACT_SLEEP;
      r = $urandom_range(0, 9);
      if (r < 7) c.tmo = $urandom_range(1, 6);
      else if (r == 7) c.tmo = 0;
    end else if (r < 94) c.act = ACT_WAKE;
    else if (r < 97) c.act = $urandom_range(6, 7);
    return c;
  endfunction

  initial begin
    directed_row_t rows[$];
    int cfg_sets[5][3];
    int sent;
    sched_cmd_t c;
    sched_result_t none;

    // Directed rows: fixed results only where reset state makes them obvious
    rows = '{
      '{'{ACT_SET_STATE, 0, SS_RUNNING, 0, 0}, 1, '{STAT_IGNORED, 0, 0, 0}},
      '{'{6, 3, 1, 2, 9}, 1, '{STAT_INVALID, 0, 0, 0}},
      '{'{7, 15, 7, 15, 65535}, 1, '{STAT_INVALID, 0, 0, 0}},
      '{'{ACT_SET_PRIO, 3, 0, 8, 0}, 1, '{STAT_INVALID, 0, 0, 0}},
      '{'{ACT_SET_PRIO, 4, 0, 15, 0}, 1, '{STAT_INVALID, 0, 0, 0}},
      '{'{ACT_SET_PRIO, 4, 0, 2, 0}, 1, '{STAT_INVALID, 0, 0, 0}},
      '{'{ACT_SLEEP, 2, 0, 0, 0}, 1, '{STAT_INVALID, 0, 0, 0}},
      '{'{ACT_WAKE, 5, 0, 0, 0}, 1, '{STAT_INVALID, 0, 0, 0}},
      '{'{ACT_TICK, 0, 0, 0, 0}, 1, '{STAT_DONE, 0, 0, 0}},
      '{'{ACT_YIELD, 0, 0, 0, 0}, 1, '{STAT_DONE, 0, 0, 0}},
      '{'{ACT_SET_STATE, 1, SS_READY, 0, 0}, 0, none},
      '{'{ACT_SET_STATE, 2, SS_READY, 0, 0}, 0, none},
      '{'{ACT_SET_STATE, 3, SS_SLEEP, 0, 0}, 0, none},
      '{'{ACT_SET_PRIO, 1, 0, 7, 0}, 0, none},
      '{'{ACT_SET_PRIO, 2, 0, 0, 0}, 0, none},
      '{'{ACT_SLEEP, 4, 0, 0, 1}, 0, none},
      '{'{ACT_SLEEP, 5, 0, 0, 65535}, 0, none},
      '{'{ACT_TICK, 0, 0, 0, 0}, 0, none},
      '{'{ACT_TICK, 0, 0, 0, 0}, 0, none},
      '{'{ACT_WAKE, 3, 0, 0, 0}, 0, none},
      '{'{ACT_SET_STATE, 2, SS_RUNNING, 0, 0}, 0, none},
      '{'{ACT_SET_STATE, 1, 7, 0, 0}, 0, none},
      '{'{ACT_SET_STATE, 1, SS_UNKNOWN, 0, 0}, 0, none},
      '{'{ACT_SET_STATE, 3, SS_IDLE, 0, 0}, 0, none},
      '{'{ACT_SLEEP, 3, 0, 0, 4}, 0, none}
    };
    cfg_sets = '{'{1, 0, 5}, '{0, 15, 1}, '{1, 7, 31}, '{1, 0, 0}, '{1, 15, 1}};

    sched_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].fixed, rows[i].want);
    drain();

    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      // fourth phase takes random settings
      if (ph == 3) begin
        cfg_sets[ph][1] = $urandom_range(0, 15);
        cfg_sets[ph][2] = $urandom_range(1, 31);
      end
      cfg_write(CFG_ENABLE, cfg_sets[ph][0]);
      cfg_write(CFG_EXEMPT, cfg_sets[ph][1]);
      cfg_write(CFG_SLICE, cfg_sets[ph][2]);
      if (ph == 4) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 100) hold_request = 1'b1;
        c = random_cmd();
        send_cmd(c, 1'b0, none);
        sent++;
      end
      drain();
    end

    $display("Ran %0d directed and %0d random commands over 5 settings, %0d results",
             rows.size(), sent, results_seen);
    $display("Scheduling decisions: %0d, sleepers woken by ticks: %0d",
             switch_total, woke_total);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/pts_pkg.sv
hw/rtl/pts_dp.sv
hw/rtl/pts_ctrl.sv
hw/rtl/priority_task_scheduler.sv
tb/testbench.sv
